// ----- design/cci_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle collision impulse package
// Field widths, register indexes, reset values and pipeline step counts
// shared by the collision unit and its arithmetic pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

  // Field widths of one input item and one result item.
  localparam int unsigned POS_W    = 24;
  localparam int unsigned RAD_W    = 16;
  localparam int unsigned MASS_W   = 16;
  localparam int unsigned FORCE_W  = 32;
  localparam int unsigned IN_W     = 256;
  localparam int unsigned OUT_W    = 112;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_TIME_STEP      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESTITUTION    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONTACT_MARGIN = 2'd2;

  localparam logic [15:0] TIME_STEP_RST      = 16'd26;
  localparam logic [7:0]  RESTITUTION_RST    = 8'd51;
  localparam logic [15:0] CONTACT_MARGIN_RST = 16'd256;

  // The unit normal carries 16 fraction bits; restitution is Q0.8.
  localparam int unsigned NORM_BITS = 16;
  localparam int unsigned REST_BITS = 8;

  // Root of a sum of two squares of 24 bit magnitudes.
  localparam int unsigned ROOT_W = 25;

  // Dependent add/compare steps placed between two pipeline registers.
  localparam int unsigned STAGE_STEPS = 4;

endpackage

`default_nettype wire

// ----- design/circle_collision_impulse_unit.sv -----
// ----------------------------------------------------------------------------
// Circle collision impulse unit
// Contact test, impulse force and push-out for a pair of circles.
// ----------------------------------------------------------------------------
// The unit takes one circle pair per clock while the output side does not
// stall, and returns one result per pair. The pipeline holds the square root
// of the centre distance (7 stages), the normal division (5 stages) and the
// force division by the time step (8 stages), each resolving four bits per
// stage, plus the multiplier stages around them. Every stage has its own
// valid bit and only stalls when the stage after it is full and stalled,
// so bubbles are squeezed out behind a waiting result. Configuration is taken
// at any time but must only change while no pair is in flight.
`default_nettype none

module circle_collision_impulse_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass
  input  wire logic [cci_pkg::IN_W-1:0]        s_axis_tdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // force_x, force_y, new_a_pos_x, new_a_pos_y
  output logic      [cci_pkg::OUT_W-1:0]       m_axis_tdata,
  // hit
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic                            cfg_we_i,
  input  wire logic [cci_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [cci_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned S       = cci_pkg::STAGE_STEPS;
  localparam int unsigned NQ_W    = cci_pkg::NORM_BITS + 1;
  localparam int unsigned ME_W    = cci_pkg::MASS_W;
  localparam int unsigned FQ_W    = cci_pkg::FORCE_W - 1;
  localparam int unsigned RT_W    = cci_pkg::ROOT_W;
  localparam int unsigned SJ_W    = 45;
  localparam int unsigned JW      = SJ_W - FRAC_BITS;
  localparam int unsigned JL      = 24;
  localparam int unsigned JH      = JW - JL;
  localparam int unsigned PW      = JW + NQ_W;
  localparam int unsigned NUM_W   = JW + 1 + FRAC_BITS;

  localparam int unsigned ST_IN   = 0;
  localparam int unsigned ST_SQ   = 1;
  localparam int unsigned ST_ME0  = 1;
  localparam int unsigned ME_ST   = (ME_W + S - 1) / S;
  localparam int unsigned ST_SUM  = 2;
  localparam int unsigned ST_RT0  = 3;
  localparam int unsigned RT_ST   = (RT_W + S - 1) / S;
  localparam int unsigned ST_GAP  = ST_RT0 + RT_ST;
  localparam int unsigned ST_NV0  = ST_GAP + 1;
  localparam int unsigned NV_ST   = (NQ_W + S - 1) / S;
  localparam int unsigned ST_NRM  = ST_NV0 + NV_ST;
  localparam int unsigned ST_MUL  = ST_NRM + 1;
  localparam int unsigned ST_VN   = ST_MUL + 1;
  localparam int unsigned ST_APP  = ST_VN + 1;
  localparam int unsigned ST_SCL  = ST_APP + 1;
  localparam int unsigned ST_J    = ST_SCL + 1;
  localparam int unsigned ST_PP   = ST_J + 1;
  localparam int unsigned ST_NUM  = ST_PP + 1;
  localparam int unsigned ST_FD0  = ST_NUM + 1;
  localparam int unsigned FD_ST   = (FQ_W + S - 1) / S;
  localparam int unsigned ST_OUT  = ST_FD0 + FD_ST;
  localparam int unsigned NS      = ST_OUT + 1;

  // Per-item values that travel alongside the arithmetic.
  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [24:0] dvx;
    logic signed [24:0] dvy;
    logic [23:0]        adx;
    logic [23:0]        ady;
    logic               sx;
    logic               sy;
    logic               zero;
    logic               den_zero;
    logic [16:0]        rsum;
    logic signed [17:0] gap;
    logic               contact;
    logic [15:0]        meff;
    logic [16:0]        nmx;
    logic [16:0]        nmy;
    logic               hit;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic               satx;
    logic               saty;
  } side_t;

  // Configuration registers.
  logic [15:0] time_step_q, margin_q;
  logic [7:0]  rest_q;
  logic [15:0] tstep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= cci_pkg::TIME_STEP_RST;
      rest_q      <= cci_pkg::RESTITUTION_RST;
      margin_q    <= cci_pkg::CONTACT_MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        cci_pkg::CFG_TIME_STEP:      time_step_q <= cfg_wdata_i;
        cci_pkg::CFG_RESTITUTION:    rest_q      <= cfg_wdata_i[7:0];
        cci_pkg::CFG_CONTACT_MARGIN: margin_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero step acts as the smallest step.
  assign tstep = (time_step_q == 16'd0) ? 16'd1 : time_step_q;

  // Stage valids and the backward ready chain.
  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  assign rdy[NS] = m_axis_tready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];

  // Input fields.
  logic [23:0] in_ax, in_ay, in_avx, in_avy, in_bx, in_by, in_bvx, in_bvy;
  logic [15:0] in_ra, in_ma, in_rb, in_mb;
  logic signed [24:0] dx_w, dy_w;

  assign in_ax  = s_axis_tdata[23:0];
  assign in_ay  = s_axis_tdata[47:24];
  assign in_avx = s_axis_tdata[71:48];
  assign in_avy = s_axis_tdata[95:72];
  assign in_ra  = s_axis_tdata[111:96];
  assign in_ma  = s_axis_tdata[127:112];
  assign in_bx  = s_axis_tdata[151:128];
  assign in_by  = s_axis_tdata[175:152];
  assign in_bvx = s_axis_tdata[199:176];
  assign in_bvy = s_axis_tdata[223:200];
  assign in_rb  = s_axis_tdata[239:224];
  assign in_mb  = s_axis_tdata[255:240];

  assign dx_w = $signed({in_ax[23], in_ax}) - $signed({in_bx[23], in_bx});
  assign dy_w = $signed({in_ay[23], in_ay}) - $signed({in_by[23], in_by});

  // Stage registers.
  side_t side_q [ST_OUT];
  side_t side_d [ST_OUT];

  logic [31:0]              mp_q;
  logic [16:0]              den_q;
  logic [47:0]              sqx_q, sqy_q;
  logic [48:0]              sum_q;
  logic [RT_W-1:0]          dist_q;
  logic signed [17:0]       nx_q, ny_q;
  logic signed [42:0]       pvx_q, pvy_q;
  logic signed [35:0]       gx_q, gy_q;
  logic signed [43:0]       vn_q;
  logic signed [19:0]       tx_q, ty_q;
  logic [27:0]              app_q;
  logic [28:0]              scale_q;
  logic [JW-1:0]            j_q;
  logic [JL+NQ_W-1:0]       plx_q, ply_q;
  logic [JH+NQ_W-1:0]       phx_q, phy_q;
  logic [NUM_W-1:0]         numx_q, numy_q;
  logic                     hit_q;
  logic [31:0]              fx_q, fy_q;
  logic [23:0]              opx_q, opy_q;

  // Arithmetic unit outputs.
  logic [RT_W-1:0] root;
  logic [ME_W-1:0] me_q;
  logic [NQ_W-1:0] nqx, nqy;
  logic [FQ_W-1:0] fqx, fqy;

  // Combinational stage logic.
  logic signed [25:0] gap_w;
  logic signed [35:0] gx_r, gy_r;
  logic signed [25:0] npx_w, npy_w;
  logic signed [23:0] satpx, satpy;
  logic signed [43:0] neg_vn;
  logic [36:0]        sp_w;
  logic [SJ_W-1:0]    jp_w;
  logic [PW-1:0]      pfx_w, pfy_w;
  logic [NUM_W-1:0]   numx_w, numy_w;
  logic [31:0]        fx_d, fy_d;

  always_comb begin
    side_d[0]          = '0;
    side_d[0].ax       = in_ax;
    side_d[0].ay       = in_ay;
    side_d[0].dvx      = $signed({in_avx[23], in_avx}) - $signed({in_bvx[23], in_bvx});
    side_d[0].dvy      = $signed({in_avy[23], in_avy}) - $signed({in_bvy[23], in_bvy});
    side_d[0].adx      = dx_w[24] ? 24'(-dx_w) : dx_w[23:0];
    side_d[0].ady      = dy_w[24] ? 24'(-dy_w) : dy_w[23:0];
    side_d[0].sx       = dx_w[24];
    side_d[0].sy       = dy_w[24];
    side_d[0].zero     = (dx_w == 25'sd0) && (dy_w == 25'sd0);
    side_d[0].den_zero = ({1'b0, in_ma} + {1'b0, in_mb}) == 17'd0;
    side_d[0].rsum     = {1'b0, in_ra} + {1'b0, in_rb};
    for (int k = 1; k < ST_OUT; k++) begin
      side_d[k] = side_q[k-1];
    end

    // Effective mass, zero when both masses are zero.
    side_d[ST_ME0+ME_ST].meff = side_q[ST_ME0+ME_ST-1].den_zero ? '0 : me_q;

    // Gap between the circle edges and the contact test.
    gap_w = $signed({1'b0, root}) - $signed({9'b0, side_q[ST_GAP-1].rsum});
    side_d[ST_GAP].gap     = gap_w[17:0];
    side_d[ST_GAP].contact = !side_q[ST_GAP-1].zero &&
                             (gap_w <= $signed({10'b0, margin_q}));

    side_d[ST_NRM].nmx = nqx;
    side_d[ST_NRM].nmy = nqy;

    // Push-out step, rounded toward zero.
    gx_r  = gx_q + (gx_q[35] ? 36'sd65535 : 36'sd0);
    gy_r  = gy_q + (gy_q[35] ? 36'sd65535 : 36'sd0);
    npx_w = $signed({{2{side_q[ST_APP-1].ax[23]}}, side_q[ST_APP-1].ax}) -
            $signed({{6{tx_q[19]}}, tx_q});
    npy_w = $signed({{2{side_q[ST_APP-1].ay[23]}}, side_q[ST_APP-1].ay}) -
            $signed({{6{ty_q[19]}}, ty_q});
    if (npx_w > 26'sd8388607) begin
      satpx = 24'sh7FFFFF;
    end else if (npx_w < -26'sd8388608) begin
      satpx = 24'sh800000;
    end else begin
      satpx = npx_w[23:0];
    end
    if (npy_w > 26'sd8388607) begin
      satpy = 24'sh7FFFFF;
    end else if (npy_w < -26'sd8388608) begin
      satpy = 24'sh800000;
    end else begin
      satpy = npy_w[23:0];
    end
    side_d[ST_APP].hit = side_q[ST_APP-1].contact && vn_q[43];
    side_d[ST_APP].px  = side_d[ST_APP].hit ? satpx : side_q[ST_APP-1].ax;
    side_d[ST_APP].py  = side_d[ST_APP].hit ? satpy : side_q[ST_APP-1].ay;
    neg_vn = -vn_q;

    sp_w = app_q * {1'b1, rest_q};
    jp_w = scale_q * side_q[ST_J-1].meff;

    // Force numerator j * |n| / 2^16 * 2^F, then the saturation test.
    pfx_w  = (PW'(phx_q) << JL) + PW'(plx_q);
    pfy_w  = (PW'(phy_q) << JL) + PW'(ply_q);
    numx_w = {pfx_w[PW-1:cci_pkg::NORM_BITS], {FRAC_BITS{1'b0}}};
    numy_w = {pfy_w[PW-1:cci_pkg::NORM_BITS], {FRAC_BITS{1'b0}}};
    side_d[ST_NUM].satx = {1'b0, numx_w[NUM_W-1:FQ_W]} >= tstep;
    side_d[ST_NUM].saty = {1'b0, numy_w[NUM_W-1:FQ_W]} >= tstep;

    // Force sign and saturation.
    if (!side_q[ST_OUT-1].hit) begin
      fx_d = '0;
    end else if (side_q[ST_OUT-1].sx) begin
      fx_d = side_q[ST_OUT-1].satx ? 32'h8000_0000 : 32'(-{1'b0, fqx});
    end else begin
      fx_d = side_q[ST_OUT-1].satx ? 32'h7FFF_FFFF : {1'b0, fqx};
    end
    if (!side_q[ST_OUT-1].hit) begin
      fy_d = '0;
    end else if (side_q[ST_OUT-1].sy) begin
      fy_d = side_q[ST_OUT-1].saty ? 32'h8000_0000 : 32'(-{1'b0, fqy});
    end else begin
      fy_d = side_q[ST_OUT-1].saty ? 32'h7FFF_FFFF : {1'b0, fqy};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ST_OUT; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_d[k];
      end
    end
    if (rdy[ST_IN]) begin
      mp_q  <= in_ma * in_mb;
      den_q <= {1'b0, in_ma} + {1'b0, in_mb};
    end
    if (rdy[ST_SQ]) begin
      sqx_q <= side_q[ST_SQ-1].adx * side_q[ST_SQ-1].adx;
      sqy_q <= side_q[ST_SQ-1].ady * side_q[ST_SQ-1].ady;
    end
    if (rdy[ST_SUM]) begin
      sum_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
    end
    if (rdy[ST_GAP]) begin
      dist_q <= root;
    end
    if (rdy[ST_NRM]) begin
      nx_q <= side_q[ST_NRM-1].sx ? -$signed({1'b0, nqx}) : $signed({1'b0, nqx});
      ny_q <= side_q[ST_NRM-1].sy ? -$signed({1'b0, nqy}) : $signed({1'b0, nqy});
    end
    if (rdy[ST_MUL]) begin
      pvx_q <= side_q[ST_MUL-1].dvx * nx_q;
      pvy_q <= side_q[ST_MUL-1].dvy * ny_q;
      gx_q  <= nx_q * side_q[ST_MUL-1].gap;
      gy_q  <= ny_q * side_q[ST_MUL-1].gap;
    end
    if (rdy[ST_VN]) begin
      vn_q <= 44'(pvx_q) + 44'(pvy_q);
      tx_q <= gx_r[35:16];
      ty_q <= gy_r[35:16];
    end
    if (rdy[ST_APP]) begin
      app_q <= neg_vn[43:16];
    end
    if (rdy[ST_SCL]) begin
      scale_q <= sp_w[36:cci_pkg::REST_BITS];
    end
    if (rdy[ST_J]) begin
      j_q <= jp_w[SJ_W-1:FRAC_BITS];
    end
    if (rdy[ST_PP]) begin
      plx_q <= j_q[JL-1:0] * side_q[ST_PP-1].nmx;
      ply_q <= j_q[JL-1:0] * side_q[ST_PP-1].nmy;
      phx_q <= j_q[JW-1:JL] * side_q[ST_PP-1].nmx;
      phy_q <= j_q[JW-1:JL] * side_q[ST_PP-1].nmy;
    end
    if (rdy[ST_NUM]) begin
      numx_q <= numx_w;
      numy_q <= numy_w;
    end
    if (rdy[ST_OUT]) begin
      hit_q <= side_q[ST_OUT-1].hit;
      fx_q  <= fx_d;
      fy_q  <= fy_d;
      opx_q <= side_q[ST_OUT-1].px;
      opy_q <= side_q[ST_OUT-1].py;
    end
  end

  // Centre distance.
  cci_sqrt_pipe #(
    .RW   (RT_W),
    .STEPS(S)
  ) u_sqrt (
    .clk_i (clk_i),
    .en_i  (rdy[ST_RT0 +: RT_ST]),
    .x_i   ({1'b0, sum_q}),
    .root_o(root)
  );

  // Effective mass ma*mb/(ma+mb).
  cci_div_pipe #(
    .DW   (17),
    .QW   (ME_W),
    .STEPS(S)
  ) u_meff (
    .clk_i(clk_i),
    .en_i (rdy[ST_ME0 +: ME_ST]),
    .r0_i ({1'b0, mp_q[31:16]}),
    .d_i  (den_q),
    .lo_i (mp_q[15:0]),
    .q_o  (me_q)
  );

  // Normal components |d| * 2^16 / distance.
  cci_div_pipe #(
    .DW   (RT_W),
    .QW   (NQ_W),
    .STEPS(S)
  ) u_normx (
    .clk_i(clk_i),
    .en_i (rdy[ST_NV0 +: NV_ST]),
    .r0_i ({2'b00, side_q[ST_GAP].adx[23:1]}),
    .d_i  (dist_q),
    .lo_i ({side_q[ST_GAP].adx[0], 16'b0}),
    .q_o  (nqx)
  );

  cci_div_pipe #(
    .DW   (RT_W),
    .QW   (NQ_W),
    .STEPS(S)
  ) u_normy (
    .clk_i(clk_i),
    .en_i (rdy[ST_NV0 +: NV_ST]),
    .r0_i ({2'b00, side_q[ST_GAP].ady[23:1]}),
    .d_i  (dist_q),
    .lo_i ({side_q[ST_GAP].ady[0], 16'b0}),
    .q_o  (nqy)
  );

  // Force magnitudes divided by the time step.
  cci_div_pipe #(
    .DW   (16),
    .QW   (FQ_W),
    .STEPS(S)
  ) u_forcex (
    .clk_i(clk_i),
    .en_i (rdy[ST_FD0 +: FD_ST]),
    .r0_i ({1'b0, numx_q[NUM_W-1:FQ_W]}),
    .d_i  (tstep),
    .lo_i (numx_q[FQ_W-1:0]),
    .q_o  (fqx)
  );

  cci_div_pipe #(
    .DW   (16),
    .QW   (FQ_W),
    .STEPS(S)
  ) u_forcey (
    .clk_i(clk_i),
    .en_i (rdy[ST_FD0 +: FD_ST]),
    .r0_i ({1'b0, numy_q[NUM_W-1:FQ_W]}),
    .d_i  (tstep),
    .lo_i (numy_q[FQ_W-1:0]),
    .q_o  (fqy)
  );

  assign m_axis_tvalid = v_q[ST_OUT];
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = {opy_q, opx_q, fy_q, fx_q};

  // A result without a hit carries no force.
  a_no_hit_no_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:0] == 64'b0)
    else $error("force reported without a hit");

  // Coincident centres never count as contact.
  a_zero_no_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_GAP] |-> !(side_q[ST_GAP].zero && side_q[ST_GAP].contact))
    else $error("contact with coincident centres");

  // A pair in contact always has a nonzero centre distance as the divisor.
  a_contact_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_GAP] && side_q[ST_GAP].contact |-> dist_q != '0)
    else $error("contact with zero centre distance");

endmodule

`default_nettype wire

// ----- design/cci_div_pipe.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned long division, a few quotient bits per stage. The partial
// remainder r0_i must be below the divisor; lo_i holds the numerator bits
// that are brought in, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_div_pipe #(
  parameter int unsigned DW    = 16,
  parameter int unsigned QW    = 16,
  parameter int unsigned STEPS = cci_pkg::STAGE_STEPS,
  localparam int unsigned STAGES = (QW + STEPS - 1) / STEPS
) (
  input  wire logic              clk_i,
  input  wire logic [STAGES-1:0] en_i,
  input  wire logic [DW-1:0]     r0_i,
  input  wire logic [DW-1:0]     d_i,
  input  wire logic [QW-1:0]     lo_i,
  output logic      [QW-1:0]     q_o
);

  logic [DW-1:0] r_q  [STAGES];
  logic [DW-1:0] d_q  [STAGES];
  logic [QW-1:0] lo_q [STAGES];
  logic [QW-1:0] q_q  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DW-1:0] r_in, d_in, r_d;
    logic [QW-1:0] lo_in, q_in, lo_d, q_d;

    if (s == 0) begin : g_first
      assign r_in  = r0_i;
      assign d_in  = d_i;
      assign lo_in = lo_i;
      assign q_in  = '0;
    end else begin : g_next
      assign r_in  = r_q[s-1];
      assign d_in  = d_q[s-1];
      assign lo_in = lo_q[s-1];
      assign q_in  = q_q[s-1];
    end

    always_comb begin
      logic [DW:0] rw;
      rw   = '0;
      r_d  = r_in;
      lo_d = lo_in;
      q_d  = q_in;
      for (int i = 0; i < STEPS; i++) begin
        if (s * STEPS + i < QW) begin
          rw   = {r_d, lo_d[QW-1]};
          lo_d = lo_d << 1;
          if (rw >= {1'b0, d_in}) begin
            rw  = rw - {1'b0, d_in};
            q_d = {q_d[QW-2:0], 1'b1};
          end else begin
            q_d = {q_d[QW-2:0], 1'b0};
          end
          r_d = rw[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        r_q[s]  <= r_d;
        d_q[s]  <= d_in;
        lo_q[s] <= lo_d;
        q_q[s]  <= q_d;
      end
    end
  end

  assign q_o = q_q[STAGES-1];

endmodule

`default_nettype wire

// ----- design/cci_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, a few root bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_sqrt_pipe #(
  parameter int unsigned RW    = cci_pkg::ROOT_W,
  parameter int unsigned STEPS = cci_pkg::STAGE_STEPS,
  localparam int unsigned STAGES = (RW + STEPS - 1) / STEPS
) (
  input  wire logic              clk_i,
  input  wire logic [STAGES-1:0] en_i,
  input  wire logic [2*RW-1:0]   x_i,
  output logic      [RW-1:0]     root_o
);

  logic [2*RW-1:0] x_q  [STAGES];
  logic [RW-1:0]   rt_q [STAGES];
  logic [RW+1:0]   rm_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [2*RW-1:0] x_in, x_d;
    logic [RW-1:0]   rt_in, rt_d;
    logic [RW+1:0]   rm_in, rm_d;

    if (s == 0) begin : g_first
      assign x_in  = x_i;
      assign rt_in = '0;
      assign rm_in = '0;
    end else begin : g_next
      assign x_in  = x_q[s-1];
      assign rt_in = rt_q[s-1];
      assign rm_in = rm_q[s-1];
    end

    always_comb begin
      logic [RW+3:0] rw, tr;
      rw   = '0;
      tr   = '0;
      x_d  = x_in;
      rt_d = rt_in;
      rm_d = rm_in;
      for (int i = 0; i < STEPS; i++) begin
        if (s * STEPS + i < RW) begin
          rw  = {rm_d, x_d[2*RW-1 -: 2]};
          x_d = x_d << 2;
          tr  = {2'b00, rt_d, 2'b01};
          if (rw >= tr) begin
            rw   = rw - tr;
            rt_d = {rt_d[RW-2:0], 1'b1};
          end else begin
            rt_d = {rt_d[RW-2:0], 1'b0};
          end
          rm_d = rw[RW+1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        x_q[s]  <= x_d;
        rt_q[s] <= rt_d;
        rm_q[s] <= rm_d;
      end
    end
  end

  assign root_o = rt_q[STAGES-1];

endmodule

`default_nettype wire
